// File: design/sfs_pkg.sv
// Shared types and constants for the servo flip sequencer.
package sfs_pkg;

    localparam int POSITION_BITS = 12;
    localparam int TIMER_BITS = 12;
    localparam int POLL_BITS = 5;
    localparam int CFG_INDEX_BITS = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = PTR_BITS + 1;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [POLL_BITS-1:0] POLL_MAX = {POLL_BITS{1'b1}};
    localparam logic [POLL_BITS-1:0] POLL_PERIOD = POLL_BITS'(20);
    localparam logic [TIMER_BITS-1:0] COMPRESS_WAIT = TIMER_BITS'(750);
    localparam logic [TIMER_BITS-1:0] MIDDLE_IN_SETTLE = TIMER_BITS'(200);
    localparam logic [POSITION_BITS-1:0] TOLERANCE_RESET = POSITION_BITS'(50);
    localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = TIMER_BITS'(2500);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_ACK   = 3'd3,
        CMD_REPLY = 3'd4,
        CMD_OTHER = 3'd5
    } cmd_kind_t;

    typedef enum logic [1:0] {
        REQ_NONE       = 2'd0,
        REQ_WRITE_GOAL = 2'd1,
        REQ_READ_POS   = 2'd2,
        REQ_TORQUE_OFF = 2'd3
    } request_t;

    typedef enum logic [1:0] {
        SERVO_BOTTOM = 2'd0,
        SERVO_TOP    = 2'd1,
        SERVO_MIDDLE = 2'd2
    } servo_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_MIDDLE_OUT = 3'd1,
        ERR_ROTATE     = 3'd2,
        ERR_MIDDLE_IN  = 3'd3,
        ERR_RELEASE    = 3'd4
    } error_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COMPRESS   = 3'd0,
        CFG_MIDDLE_OUT = 3'd1,
        CFG_TOP_A      = 3'd2,
        CFG_TOP_B      = 3'd3,
        CFG_MIDDLE_IN  = 3'd4,
        CFG_RELEASE    = 3'd5,
        CFG_TOLERANCE  = 3'd6,
        CFG_TIMEOUT    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic                     failed;
        logic [POSITION_BITS-1:0] position;
    } item_t;

    typedef struct packed {
        request_t                 request;
        servo_t                   servo;
        logic [POSITION_BITS-1:0] goal;
        logic                     done;
        error_t                   error_code;
        logic                     busy;
        logic                     last;
    } result_t;

endpackage

// File: design/sfs_front.sv
// Input side: decodes each command and holds it in a short queue for the sequencer.
module sfs_front
    import sfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [2:0]               cmd,
    input  logic                     reply_failed,
    input  logic [POSITION_BITS-1:0] position,
    output logic                     full,
    output logic                     item_valid,
    output item_t                    item,
    input  logic                     item_take
);

    item_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;
    item_t                item_in;

    always_comb
    begin
        item_in.failed = reply_failed;
        item_in.position = position;
        case (cmd)
            CMD_TICK:  item_in.kind = CMD_TICK;
            CMD_START: item_in.kind = CMD_START;
            CMD_STOP:  item_in.kind = CMD_STOP;
            CMD_ACK:   item_in.kind = CMD_ACK;
            CMD_REPLY: item_in.kind = CMD_REPLY;
            default:   item_in.kind = CMD_OTHER;
        endcase
    end

    assign full = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = item_take && item_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/sfs_resq.sv
// Output side: queue of finished results waiting to be taken.
module sfs_resq
    import sfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    res_ready,
    output logic    empty,
    output result_t head,
    input  logic    pop
);

    result_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign res_ready = (count_reg != COUNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = res_valid && res_ready;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/sfs_core.sv
// Sequencer: configuration registers, flip sequence state and move tracking.
module sfs_core
    import sfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [POSITION_BITS-1:0]  cfg_data,
    input  logic                      item_valid,
    input  item_t                     item,
    output logic                      item_take,
    input  logic                      res_ready,
    output logic                      res_valid,
    output result_t                   res
);

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_COMPRESS   = 3'd1,
        ST_MIDDLE_OUT = 3'd2,
        ST_ROTATE     = 3'd3,
        ST_MIDDLE_IN  = 3'd4,
        ST_RELEASE    = 3'd5
    } step_t;

    typedef enum logic [1:0] {
        PH_ACK    = 2'd0,
        PH_POLL   = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    localparam logic [1:0] STOP_LAST = 2'd2;

    logic [POSITION_BITS-1:0] compress_reg;
    logic [POSITION_BITS-1:0] middle_out_reg;
    logic [POSITION_BITS-1:0] top_a_reg;
    logic [POSITION_BITS-1:0] top_b_reg;
    logic [POSITION_BITS-1:0] middle_in_reg;
    logic [POSITION_BITS-1:0] release_reg;
    logic [POSITION_BITS-1:0] tolerance_reg;
    logic [TIMER_BITS-1:0]    timeout_reg;

    step_t                    step_reg, step_next;
    phase_t                   phase_reg, phase_next;
    logic                     toggle_reg, toggle_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [TIMER_BITS-1:0]    move_elapsed_reg, move_elapsed_next;
    logic [TIMER_BITS-1:0]    settle_elapsed_reg, settle_elapsed_next;
    logic [POLL_BITS-1:0]     poll_elapsed_reg, poll_elapsed_next;
    error_t                   error_reg, error_next;
    logic [1:0]               stop_cnt_reg, stop_cnt_next;

    logic [TIMER_BITS-1:0]    move_bump;
    logic [TIMER_BITS-1:0]    settle_bump;
    logic [POLL_BITS-1:0]     poll_bump;
    logic [POSITION_BITS-1:0] diff;
    logic                     in_move;
    logic                     go;
    logic                     do_fail;
    logic                     do_succeed;
    logic                     do_begin;
    step_t                    begin_step;
    logic [POSITION_BITS-1:0] begin_target;

    function automatic servo_t servo_of(input step_t s);
        case (s)
            ST_ROTATE:  servo_of = SERVO_TOP;
            ST_RELEASE: servo_of = SERVO_BOTTOM;
            default:    servo_of = SERVO_MIDDLE;
        endcase
    endfunction

    function automatic error_t error_of(input step_t s);
        case (s)
            ST_MIDDLE_OUT: error_of = ERR_MIDDLE_OUT;
            ST_ROTATE:     error_of = ERR_ROTATE;
            ST_MIDDLE_IN:  error_of = ERR_MIDDLE_IN;
            ST_RELEASE:    error_of = ERR_RELEASE;
            default:       error_of = ERR_NONE;
        endcase
    endfunction

    assign move_bump = (move_elapsed_reg != TIMER_MAX) ? move_elapsed_reg + 1'b1
                                                       : move_elapsed_reg;
    assign settle_bump = (settle_elapsed_reg != TIMER_MAX) ? settle_elapsed_reg + 1'b1
                                                           : settle_elapsed_reg;
    assign poll_bump = (poll_elapsed_reg != POLL_MAX) ? poll_elapsed_reg + 1'b1
                                                      : poll_elapsed_reg;
    assign diff = (item.position >= target_reg) ? item.position - target_reg
                                                : target_reg - item.position;
    assign in_move = (step_reg == ST_MIDDLE_OUT) || (step_reg == ST_ROTATE)
                  || (step_reg == ST_MIDDLE_IN) || (step_reg == ST_RELEASE);
    assign go = item_valid && res_ready;

    always_comb
    begin
        step_next = step_reg;
        phase_next = phase_reg;
        toggle_next = toggle_reg;
        target_next = target_reg;
        move_elapsed_next = move_elapsed_reg;
        settle_elapsed_next = settle_elapsed_reg;
        poll_elapsed_next = poll_elapsed_reg;
        error_next = error_reg;
        stop_cnt_next = stop_cnt_reg;
        item_take = 1'b0;
        res_valid = 1'b0;
        res = '0;
        do_fail = 1'b0;
        do_succeed = 1'b0;
        do_begin = 1'b0;
        begin_step = ST_IDLE;
        begin_target = '0;

        if (go)
        begin
            res_valid = 1'b1;
            case (item.kind)
                CMD_TICK:
                begin
                    move_elapsed_next = move_bump;
                    settle_elapsed_next = settle_bump;
                    poll_elapsed_next = poll_bump;
                    if (step_reg == ST_COMPRESS)
                    begin
                        if (settle_bump > COMPRESS_WAIT)
                        begin
                            do_begin = 1'b1;
                            begin_step = ST_MIDDLE_OUT;
                            begin_target = middle_out_reg;
                        end
                    end
                    else if (in_move)
                    begin
                        if (phase_reg == PH_POLL)
                        begin
                            if (move_bump > timeout_reg)
                            begin
                                do_fail = 1'b1;
                            end
                            else if (poll_bump > POLL_PERIOD)
                            begin
                                poll_elapsed_next = '0;
                                res.request = REQ_READ_POS;
                                res.servo = servo_of(step_reg);
                            end
                        end
                        else if (phase_reg == PH_SETTLE)
                        begin
                            if (settle_bump > MIDDLE_IN_SETTLE)
                            begin
                                do_succeed = 1'b1;
                            end
                        end
                    end
                end
                CMD_START:
                begin
                    if (step_reg == ST_IDLE)
                    begin
                        phase_next = PH_ACK;
                        target_next = '0;
                        move_elapsed_next = '0;
                        settle_elapsed_next = '0;
                        poll_elapsed_next = '0;
                        error_next = ERR_NONE;
                        step_next = ST_COMPRESS;
                        res.request = REQ_WRITE_GOAL;
                        res.servo = SERVO_BOTTOM;
                        res.goal = compress_reg;
                    end
                end
                CMD_STOP:
                begin
                    res.request = REQ_TORQUE_OFF;
                    res.servo = servo_t'(stop_cnt_reg);
                    if (stop_cnt_reg == STOP_LAST)
                    begin
                        stop_cnt_next = '0;
                        step_next = ST_IDLE;
                        phase_next = PH_ACK;
                        target_next = '0;
                        move_elapsed_next = '0;
                        settle_elapsed_next = '0;
                        poll_elapsed_next = '0;
                    end
                    else
                    begin
                        stop_cnt_next = stop_cnt_reg + 1'b1;
                    end
                end
                CMD_ACK:
                begin
                    if (in_move && (phase_reg == PH_ACK))
                    begin
                        if (item.failed || (move_elapsed_reg > timeout_reg))
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_POLL;
                            poll_elapsed_next = '0;
                        end
                    end
                end
                CMD_REPLY:
                begin
                    if (in_move && (phase_reg == PH_POLL))
                    begin
                        if (item.failed || (move_elapsed_reg > timeout_reg))
                        begin
                            do_fail = 1'b1;
                        end
                        else if (diff <= tolerance_reg)
                        begin
                            if (step_reg == ST_MIDDLE_IN)
                            begin
                                phase_next = PH_SETTLE;
                                settle_elapsed_next = '0;
                            end
                            else
                            begin
                                do_succeed = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (do_succeed)
            begin
                case (step_reg)
                    ST_MIDDLE_OUT:
                    begin
                        do_begin = 1'b1;
                        begin_step = ST_ROTATE;
                        begin_target = toggle_reg ? top_a_reg : top_b_reg;
                        toggle_next = !toggle_reg;
                    end
                    ST_ROTATE:
                    begin
                        do_begin = 1'b1;
                        begin_step = ST_MIDDLE_IN;
                        begin_target = middle_in_reg;
                    end
                    ST_MIDDLE_IN:
                    begin
                        do_begin = 1'b1;
                        begin_step = ST_RELEASE;
                        begin_target = release_reg;
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                        res.done = 1'b1;
                    end
                endcase
            end

            if (do_fail)
            begin
                error_next = error_of(step_reg);
                step_next = ST_IDLE;
                res.done = 1'b1;
            end

            if (do_fail || do_begin || (do_succeed && step_next == ST_IDLE))
            begin
                phase_next = PH_ACK;
                target_next = '0;
                move_elapsed_next = '0;
                settle_elapsed_next = '0;
                poll_elapsed_next = '0;
            end

            if (do_begin)
            begin
                step_next = begin_step;
                target_next = begin_target;
                res.request = REQ_WRITE_GOAL;
                res.servo = servo_of(begin_step);
                res.goal = begin_target;
            end

            res.error_code = error_next;
            res.busy = (step_next != ST_IDLE);
            if (item.kind == CMD_STOP)
            begin
                res.busy = 1'b0;
                res.last = (stop_cnt_reg == STOP_LAST);
                item_take = (stop_cnt_reg == STOP_LAST);
            end
            else
            begin
                res.last = 1'b1;
                item_take = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compress_reg <= '0;
            middle_out_reg <= '0;
            top_a_reg <= '0;
            top_b_reg <= '0;
            middle_in_reg <= '0;
            release_reg <= '0;
            tolerance_reg <= TOLERANCE_RESET;
            timeout_reg <= TIMEOUT_RESET;
            step_reg <= ST_IDLE;
            phase_reg <= PH_ACK;
            toggle_reg <= 1'b0;
            target_reg <= '0;
            move_elapsed_reg <= '0;
            settle_elapsed_reg <= '0;
            poll_elapsed_reg <= '0;
            error_reg <= ERR_NONE;
            stop_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_COMPRESS:   compress_reg <= cfg_data;
                    CFG_MIDDLE_OUT: middle_out_reg <= cfg_data;
                    CFG_TOP_A:      top_a_reg <= cfg_data;
                    CFG_TOP_B:      top_b_reg <= cfg_data;
                    CFG_MIDDLE_IN:  middle_in_reg <= cfg_data;
                    CFG_RELEASE:    release_reg <= cfg_data;
                    CFG_TOLERANCE:  tolerance_reg <= cfg_data;
                    CFG_TIMEOUT:    timeout_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            step_reg <= step_next;
            phase_reg <= phase_next;
            toggle_reg <= toggle_next;
            target_reg <= target_next;
            move_elapsed_reg <= move_elapsed_next;
            settle_elapsed_reg <= settle_elapsed_next;
            poll_elapsed_reg <= poll_elapsed_next;
            error_reg <= error_next;
            stop_cnt_reg <= stop_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // The settle phase belongs to the middle-in move only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SETTLE) |-> (step_reg == ST_MIDDLE_IN))
        else $error("settle phase outside the middle-in move");

    // An idle sequencer has no move in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_IDLE) |-> (phase_reg == PH_ACK))
        else $error("idle with a move phase still active");

    // A torque-off burst in progress keeps its emergency stop at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stop_cnt_reg != 2'd0) |-> (item_valid && item.kind == CMD_STOP))
        else $error("torque-off burst lost its emergency stop");

    // The end of a sequence always leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.done) |=> (step_reg == ST_IDLE))
        else $error("sequence done but sequencer still running");

    // A result is never produced into a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result produced while result queue is full");
`endif

endmodule

// File: design/servo_flip_sequencer.sv
// Top level of the servo flip sequencer: input queue, sequencer and result queue.
// A pushed request is written into the input queue, then its result into the
// result queue (empty low). Throughput: one request per cycle while that queue
// has room; an emergency stop writes one torque-off result per servo, in turn.
// Reset (rst_n low, asynchronous) empties both queues, idles the sequencer and
// loads the default tolerance of 50 and move timeout of 2500 ticks.
module servo_flip_sequencer
    import sfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [2:0]                cmd,
    input  logic                      reply_failed,
    input  logic [POSITION_BITS-1:0]  position,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                request,
    output logic [1:0]                servo_select,
    output logic [POSITION_BITS-1:0]  goal,
    output logic                      sequence_done,
    output logic [2:0]                error_code,
    output logic                      busy_res,
    output logic                      last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [POSITION_BITS-1:0]  cfg_data
);

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t head;

    assign cfg_ready = 1'b1;

    sfs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .cmd          (cmd),
        .reply_failed (reply_failed),
        .position     (position),
        .full         (full),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    sfs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfs_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .empty     (empty),
        .head      (head),
        .pop       (pop)
    );

    assign request = head.request;
    assign servo_select = head.servo;
    assign goal = head.goal;
    assign sequence_done = head.done;
    assign error_code = head.error_code;
    assign busy_res = head.busy;
    assign last = head.last;

endmodule
